// ===== hdl/min_max_queue_top_assert.svh =====
// Assertion macros for the min/max queue RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef MIN_MAX_QUEUE_TOP_ASSERT_SVH
`define MIN_MAX_QUEUE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MMQ_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define MMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define MMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MMQ_ASSERT(lbl, expr, msg)
`define MMQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define MMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/mmq_pkg.sv =====
// Shared types and constants for the min/max queue.
// Used by mmq_cell and min_max_queue_top; depends on nothing.
package mmq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF  = 32;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_POP_EMPTY = 2'd1,
      STATUS_PUSH_FULL = 2'd2
   } status_type;

   // Per-cell control, decoded once at the top level.
   typedef struct packed {
      logic occupied; // cell holds an entry before this step
      logic tail;     // first free cell: a push lands here
      logic push;     // a push is taking effect this cycle
      logic pop;      // a pop is taking effect this cycle
   } cell_ctrl_type;

endpackage

// ===== hdl/mmq_cell.sv =====
// One queue cell: an entry plus the min and max of itself and all younger entries.
// Depends on mmq_pkg for cell_ctrl_type.
module mmq_cell import mmq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic signed [DATA_WIDTH-1:0] next_value,
   input  logic signed [DATA_WIDTH-1:0] next_smin,
   input  logic signed [DATA_WIDTH-1:0] next_smax,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic signed [DATA_WIDTH-1:0] smin,
   output logic signed [DATA_WIDTH-1:0] smax
);

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic signed [DATA_WIDTH-1:0] smin_ff, smin_in;
   logic signed [DATA_WIDTH-1:0] smax_ff, smax_in;

   always_comb begin
      value_in = value_ff;
      smin_in  = smin_ff;
      smax_in  = smax_ff;
      if (ctrl.pop) begin
         // advance toward the head
         value_in = next_value;
         smin_in  = next_smin;
         smax_in  = next_smax;
      end else if (ctrl.push) begin
         if (ctrl.tail) begin
            value_in = req_value;
            smin_in  = req_value;
            smax_in  = req_value;
         end else if (ctrl.occupied) begin
            // fold the new word into this cell's suffix range
            if (req_value < smin_ff) begin
               smin_in = req_value;
            end
            if (req_value > smax_ff) begin
               smax_in = req_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      smin_ff  <= smin_in;
      smax_ff  <= smax_in;
   end

   assign value = value_ff;
   assign smin  = smin_ff;
   assign smax  = smax_ff;

endmodule

// ===== hdl/min_max_queue_top.sv =====
// Min/max queue top level: a row of mmq_cell instances, oldest entry in cell 0.
// Depends on mmq_pkg, mmq_cell and min_max_queue_top_assert.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_command, req_value
//   rsp     | out       | rsp_valid/rsp_ready  | front, min, max, is_empty, status
//
// One item per cycle unless the response stalls: each cell updates in parallel
// from the broadcast word and its right-hand neighbor, so the result shows the
// cycle after accept. The cell row itself holds the result; a new item is taken
// whenever no result waits or the waiting one is taken in the same cycle.
// Reset empties the queue at once; no clearing pass.
`include "min_max_queue_top_assert.svh"
module min_max_queue_top import mmq_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_front_value,
   output logic signed [DATA_WIDTH-1:0] rsp_min_value,
   output logic signed [DATA_WIDTH-1:0] rsp_max_value,
   output logic                         rsp_is_empty,
   output logic [1:0]                   rsp_status
);

   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;

   logic req_accept;
   logic is_push;
   logic q_full;
   logic q_empty;
   logic do_push;
   logic do_pop;

   logic signed [DATA_WIDTH-1:0] value_w [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] smin_w  [QUEUE_DEPTH];
   logic signed [DATA_WIDTH-1:0] smax_w  [QUEUE_DEPTH];

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_push    = (req_command == CMD_PUSH);
   assign q_full     = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign q_empty    = (count_ff == '0);
   assign do_push    = req_accept && is_push && !q_full;
   assign do_pop     = req_accept && !is_push && !q_empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_ctrl_type                ctrl;
      logic signed [DATA_WIDTH-1:0] nxt_value;
      logic signed [DATA_WIDTH-1:0] nxt_smin;
      logic signed [DATA_WIDTH-1:0] nxt_smax;

      assign ctrl.occupied = (count_ff > CountWidth'(i));
      assign ctrl.tail     = (count_ff == CountWidth'(i));
      assign ctrl.push     = do_push;
      assign ctrl.pop      = do_pop;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         // the last cell empties on a pop: hold its stale contents
         assign nxt_value = value_w[i];
         assign nxt_smin  = smin_w[i];
         assign nxt_smax  = smax_w[i];
      end else begin : g_mid
         assign nxt_value = value_w[i+1];
         assign nxt_smin  = smin_w[i+1];
         assign nxt_smax  = smax_w[i+1];
      end

      mmq_cell #(
         .DATA_WIDTH(DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .req_value (req_value),
         .next_value(nxt_value),
         .next_smin (nxt_smin),
         .next_smax (nxt_smax),
         .value     (value_w[i]),
         .smin      (smin_w[i]),
         .smax      (smax_w[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      if (req_accept) begin
         if (is_push && q_full) begin
            status_in = STATUS_PUSH_FULL;
         end else if (!is_push && q_empty) begin
            status_in = STATUS_POP_EMPTY;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= STATUS_OK;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_empty    = q_empty;
   assign rsp_status      = status_ff;
   assign rsp_front_value = q_empty ? '0 : value_w[0];
   assign rsp_min_value   = q_empty ? '0 : smin_w[0];
   assign rsp_max_value   = q_empty ? '0 : smax_w[0];

   `MMQ_ASSERT(a_count_bound, count_ff <= CountWidth'(QUEUE_DEPTH), "entry count above depth")
   `MMQ_ASSERT_NEXT(a_full_flag, req_accept && is_push && q_full, rsp_status == STATUS_PUSH_FULL && q_full, "push on full not flagged")
   `MMQ_ASSERT_IMPL(a_range_order, rsp_valid && !rsp_is_empty, rsp_min_value <= rsp_front_value && rsp_front_value <= rsp_max_value, "front outside min/max range")
   `MMQ_ASSERT_NEXT(a_count_hold, !req_accept, $stable(count_ff), "count moved without an item")

endmodule
